// File: rtl/mlbt_pkg.sv
// ----------------------------------------------------------------------------
// mlbt_pkg
// Shared types, codes and widths of the midi learn binding table.
// ----------------------------------------------------------------------------
package mlbt_pkg;

	// default table size
	localparam int DEPTH_DEFAULT = 32;

	// field widths
	localparam int CMD_W    = 3;
	localparam int TGT_W    = 16;
	localparam int DEV_W    = 4;
	localparam int CHAN_W   = 5;
	localparam int KIND_W   = 2;
	localparam int NUM_W    = 7;
	localparam int VEL_W    = 7;
	localparam int IDX_W    = 5;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 6;

	// command codes
	localparam logic [CMD_W-1:0] CMD_START_LEARN  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CANCEL_LEARN = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MIDI         = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOOKUP_CC    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LOOKUP_NOTE  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_REMOVE       = 3'd5;
	localparam logic [CMD_W-1:0] CMD_CLEAR        = 3'd6;

	// message kinds
	localparam logic [KIND_W-1:0] KIND_CC   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NOTE = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BOUND     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd5;

	// one stored binding
	typedef struct packed {
		logic [DEV_W-1:0]  dev;
		logic [CHAN_W-1:0] chan;
		logic [KIND_W-1:0] kind;
		logic [NUM_W-1:0]  num;
		logic [TGT_W-1:0]  tgt;
	} entry_t;

	// what a table pass looks for
	typedef enum logic [1:0] {
		MODE_BIND,
		MODE_REMOVE,
		MODE_LOOKUP
	} scan_mode_t;

	// closing action of an item
	typedef enum logic [2:0] {
		FIN_IGNORE,
		FIN_START,
		FIN_CANCEL,
		FIN_BIND,
		FIN_LOOKUP,
		FIN_REMOVE,
		FIN_BADIDX,
		FIN_CLEAR
	} fin_op_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       scan_start;
		logic       scan_en;
		scan_mode_t mode;
		logic       finish;
		fin_op_t    fin_op;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             bind_ok;
		logic             idx_ok;
		logic             scan_done;
		logic             hit;
	} sts_t;

endpackage

// File: rtl/midi_learn_binding_table.sv
// ----------------------------------------------------------------------------
// midi_learn_binding_table
// Ordered table of midi-to-target bindings with learn mode and lookups.
// ----------------------------------------------------------------------------
// Items are taken one at a time. Learn start and cancel, clear, an ignored
// message and a bad remove index go from decode straight to the finish
// state. A bind, a remove and a lookup make one pass over the valid entries
// of the table memory through its single read port, one entry per cycle (a
// lookup ends early at its first match). Bind and remove close up the table
// during that same pass. A finished result sits in an output register, and
// the next item is accepted while it waits; that item finishes only once the
// register is free. No clearing pass after reset: the table starts empty
// through its entry count.
// ----------------------------------------------------------------------------
module midi_learn_binding_table import mlbt_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [CMD_W-1:0]    command,
	input  logic [TGT_W-1:0]    target_id,
	input  logic [DEV_W-1:0]    device_id,
	input  logic [CHAN_W-1:0]   channel,
	input  logic [KIND_W-1:0]   message_kind,
	input  logic [NUM_W-1:0]    number,
	input  logic [VEL_W-1:0]    velocity,
	input  logic [IDX_W-1:0]    entry_index,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [IDX_W-1:0]    found_index,
	output logic [TGT_W-1:0]    found_target,
	output logic [DEV_W-1:0]    found_device,
	output logic [COUNT_W-1:0]  entry_count,
	output logic                learning
);

	ctl_t ctl;
	sts_t sts;

	// sequencer
	mlbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// table and result datapath
	mlbt_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.command      (command),
		.target_id    (target_id),
		.device_id    (device_id),
		.channel      (channel),
		.message_kind (message_kind),
		.number       (number),
		.velocity     (velocity),
		.entry_index  (entry_index),
		.status       (status),
		.found_index  (found_index),
		.found_target (found_target),
		.found_device (found_device),
		.entry_count  (entry_count),
		.learning     (learning)
	);

endmodule

// File: rtl/mlbt_ctrl.sv
// ----------------------------------------------------------------------------
// mlbt_ctrl
// Sequencer: takes an item, decodes it, runs the table pass if one is needed, closes the item.
// ----------------------------------------------------------------------------
module mlbt_ctrl import mlbt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output ctl_t ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t     state_q;
	scan_mode_t mode_q;
	fin_op_t    fin_q;
	logic       out_valid_q;
	logic       out_free;

	// result register can take a new result this cycle
	assign out_free = !out_valid_q || !out_stall;

	// commands to the datapath
	always_comb begin
		ctl.load       = (state_q == S_IDLE) && in_valid;
		ctl.scan_start = (state_q == S_DECODE);
		ctl.scan_en    = (state_q == S_SCAN);
		ctl.mode       = mode_q;
		ctl.finish     = (state_q == S_FINISH) && out_free;
		ctl.fin_op     = fin_q;
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_BIND;
			fin_q       <= FIN_IGNORE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= S_FINISH;
					case (sts.cmd)
						CMD_START_LEARN:  fin_q <= FIN_START;
						CMD_CANCEL_LEARN: fin_q <= FIN_CANCEL;
						CMD_MIDI: begin
							if (sts.bind_ok) begin
								mode_q  <= MODE_BIND;
								fin_q   <= FIN_BIND;
								state_q <= S_SCAN;
							end else begin
								fin_q <= FIN_IGNORE;
							end
						end
						CMD_LOOKUP_CC, CMD_LOOKUP_NOTE: begin
							mode_q  <= MODE_LOOKUP;
							fin_q   <= FIN_LOOKUP;
							state_q <= S_SCAN;
						end
						CMD_REMOVE: begin
							if (sts.idx_ok) begin
								mode_q  <= MODE_REMOVE;
								fin_q   <= FIN_REMOVE;
								state_q <= S_SCAN;
							end else begin
								fin_q <= FIN_BADIDX;
							end
						end
						CMD_CLEAR: fin_q <= FIN_CLEAR;
						default:   fin_q <= FIN_IGNORE;
					endcase
				end
				S_SCAN: begin
					if (sts.scan_done || ((mode_q == MODE_LOOKUP) && sts.hit)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/mlbt_datapath.sv
// ----------------------------------------------------------------------------
// mlbt_datapath
// Item registers, binding memory with compaction pass, lookup and results.
// ----------------------------------------------------------------------------
module mlbt_datapath import mlbt_pkg::*; #(
	parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_t                ctl,
	output sts_t                sts,
	input  logic [CMD_W-1:0]    command,
	input  logic [TGT_W-1:0]    target_id,
	input  logic [DEV_W-1:0]    device_id,
	input  logic [CHAN_W-1:0]   channel,
	input  logic [KIND_W-1:0]   message_kind,
	input  logic [NUM_W-1:0]    number,
	input  logic [VEL_W-1:0]    velocity,
	input  logic [IDX_W-1:0]    entry_index,
	output logic [STATUS_W-1:0] status,
	output logic [IDX_W-1:0]    found_index,
	output logic [TGT_W-1:0]    found_target,
	output logic [DEV_W-1:0]    found_device,
	output logic [COUNT_W-1:0]  entry_count,
	output logic                learning
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int XW = (CW > IDX_W) ? CW : IDX_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// latched item
	logic [CMD_W-1:0]  cmd_q;
	logic [TGT_W-1:0]  tgt_q;
	logic [DEV_W-1:0]  dev_q;
	logic [CHAN_W-1:0] ch_q;
	logic [KIND_W-1:0] kind_q;
	logic [NUM_W-1:0]  num_q;
	logic [VEL_W-1:0]  vel_q;
	logic [IDX_W-1:0]  idx_q;

	// table state
	entry_t           mem [TABLE_DEPTH];
	logic [CW-1:0]    total_q;
	logic             learn_active_q;
	logic [TGT_W-1:0] learn_target_q;

	// pass state
	logic [CW-1:0]    rd_ptr_q;
	logic [CW-1:0]    wr_ptr_q;
	logic             pend_s1;
	logic [AW-1:0]    pend_idx_s1;
	entry_t           rd_data_s1;
	logic             hit_q;
	logic [AW-1:0]    found_idx_q;
	logic [TGT_W-1:0] found_tgt_q;
	logic [DEV_W-1:0] found_dev_q;

	// result registers
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]    f_idx_q;
	logic [TGT_W-1:0]    f_tgt_q;
	logic [DEV_W-1:0]    f_dev_q;
	logic [COUNT_W-1:0]  count_q;
	logic                learning_q;

	logic              rd_issue;
	logic              eval;
	logic              match;
	logic              keep_wr;
	logic              hit_set;
	logic              app_we;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	entry_t            mem_wdata;
	entry_t            new_entry;
	logic [KIND_W-1:0] lk_kind;

	logic [CW-1:0]       total_next;
	logic                learn_next;
	logic [STATUS_W-1:0] status_next;
	logic [IDX_W-1:0]    f_idx_next;
	logic [TGT_W-1:0]    f_tgt_next;
	logic [DEV_W-1:0]    f_dev_next;

	// item capture
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= command;
			tgt_q  <= target_id;
			dev_q  <= device_id;
			ch_q   <= channel;
			kind_q <= message_kind;
			num_q  <= number;
			vel_q  <= velocity;
			idx_q  <= entry_index;
		end
	end

	// status to controller
	always_comb begin
		sts.cmd       = cmd_q;
		sts.bind_ok   = learn_active_q &&
			((kind_q == KIND_CC) || ((kind_q == KIND_NOTE) && (vel_q != '0)));
		sts.idx_ok    = XW'(idx_q) < XW'(total_q);
		sts.scan_done = (rd_ptr_q >= total_q) && !pend_s1;
		sts.hit       = hit_q;
	end

	// entry compare for the running pass
	assign lk_kind = (cmd_q == CMD_LOOKUP_CC) ? KIND_CC : KIND_NOTE;

	always_comb begin
		case (ctl.mode)
			MODE_BIND: match = (rd_data_s1.kind == kind_q) && (rd_data_s1.num == num_q) &&
				((rd_data_s1.chan == '0) || (ch_q == '0) || (rd_data_s1.chan == ch_q));
			MODE_REMOVE: match = (XW'(pend_idx_s1) == XW'(idx_q));
			MODE_LOOKUP: match = (rd_data_s1.kind == lk_kind) && (rd_data_s1.num == num_q) &&
				((rd_data_s1.chan == '0) || (rd_data_s1.chan == ch_q));
			default: match = 1'b0;
		endcase
	end

	// pass control: one read issued and one entry judged per cycle
	assign rd_issue = ctl.scan_en && (rd_ptr_q < total_q) && !hit_q;
	assign eval     = ctl.scan_en && pend_s1;
	assign keep_wr  = eval && !match && (ctl.mode != MODE_LOOKUP);
	assign hit_set  = eval && match && (ctl.mode == MODE_LOOKUP) && !hit_q;

	// append of the new binding at the end of the compacted table
	always_comb begin
		new_entry.dev  = dev_q;
		new_entry.chan = ch_q;
		new_entry.kind = kind_q;
		new_entry.num  = num_q;
		new_entry.tgt  = learn_target_q;
	end

	assign app_we    = ctl.finish && (ctl.fin_op == FIN_BIND) && (wr_ptr_q < DEPTH_C);
	assign mem_we    = keep_wr || app_we;
	assign mem_waddr = wr_ptr_q[AW-1:0];
	assign mem_wdata = app_we ? new_entry : rd_data_s1;

	// binding memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_issue) begin
			rd_data_s1  <= mem[rd_ptr_q[AW-1:0]];
			pend_idx_s1 <= rd_ptr_q[AW-1:0];
		end
	end

	// first lookup match
	always_ff @(posedge clk) begin
		if (hit_set) begin
			found_idx_q <= pend_idx_s1;
			found_tgt_q <= rd_data_s1.tgt;
			found_dev_q <= rd_data_s1.dev;
		end
	end

	// closing action of the item
	always_comb begin
		total_next  = total_q;
		learn_next  = learn_active_q;
		status_next = ST_DONE;
		f_idx_next  = '0;
		f_tgt_next  = '0;
		f_dev_next  = '0;
		case (ctl.fin_op)
			FIN_START:  learn_next = 1'b1;
			FIN_CANCEL: learn_next = 1'b0;
			FIN_BIND: begin
				learn_next = 1'b0;
				if (wr_ptr_q < DEPTH_C) begin
					total_next  = CW'(wr_ptr_q + 1'b1);
					status_next = ST_BOUND;
					f_idx_next  = IDX_W'(wr_ptr_q);
					f_tgt_next  = learn_target_q;
					f_dev_next  = dev_q;
				end else begin
					total_next  = wr_ptr_q;
					status_next = ST_FULL;
				end
			end
			FIN_LOOKUP: begin
				if (hit_q) begin
					status_next = ST_FOUND;
					f_idx_next  = IDX_W'(found_idx_q);
					f_tgt_next  = found_tgt_q;
					f_dev_next  = found_dev_q;
				end else begin
					status_next = ST_NOT_FOUND;
				end
			end
			FIN_REMOVE: total_next = wr_ptr_q;
			FIN_BADIDX: status_next = ST_BAD_INDEX;
			FIN_CLEAR: begin
				learn_next = 1'b0;
				total_next = '0;
			end
			default: status_next = ST_DONE;
		endcase
	end

	// pointers, table count and learn state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q       <= '0;
			wr_ptr_q       <= '0;
			pend_s1        <= 1'b0;
			hit_q          <= 1'b0;
			total_q        <= '0;
			learn_active_q <= 1'b0;
			learn_target_q <= '0;
		end else begin
			if (ctl.scan_start) begin
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
				pend_s1  <= 1'b0;
				hit_q    <= 1'b0;
			end else begin
				pend_s1 <= rd_issue;
				if (rd_issue) begin
					rd_ptr_q <= CW'(rd_ptr_q + 1'b1);
				end
				if (keep_wr) begin
					wr_ptr_q <= CW'(wr_ptr_q + 1'b1);
				end
				if (hit_set) begin
					hit_q <= 1'b1;
				end
			end
			if (ctl.finish) begin
				total_q        <= total_next;
				learn_active_q <= learn_next;
				if (ctl.fin_op == FIN_START) begin
					learn_target_q <= tgt_q;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			status_q   <= status_next;
			f_idx_q    <= f_idx_next;
			f_tgt_q    <= f_tgt_next;
			f_dev_q    <= f_dev_next;
			count_q    <= COUNT_W'(total_next);
			learning_q <= learn_next;
		end
	end

	assign status       = status_q;
	assign found_index  = f_idx_q;
	assign found_target = f_tgt_q;
	assign found_device = f_dev_q;
	assign entry_count  = count_q;
	assign learning     = learning_q;

	// table never holds more than its depth
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= DEPTH_C)
		else $error("entry count exceeds table depth");

	// compaction write pointer never runs ahead of the read pointer
	a_wr_behind: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q <= rd_ptr_q)
		else $error("write pointer ahead of read pointer");

	// a lookup pass leaves the memory untouched
	a_lookup_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.scan_en && (ctl.mode == MODE_LOOKUP)) |-> !mem_we)
		else $error("memory written during lookup");

	// a successful bind leaves the count one past the compacted end
	a_bind_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.finish && (ctl.fin_op == FIN_BIND) && (wr_ptr_q < DEPTH_C))
		|=> (total_q == CW'($past(wr_ptr_q) + 1'b1)))
		else $error("bind did not append one entry");

endmodule
